>>> hw/rtl/msc_pkg.sv
// Shared types, constants and coefficient tables of the minimax sine/cosine pipeline.
`timescale 1ns / 1ps

package msc_pkg;

  // Horner accumulator width: the cosine lane passes through -2.0 in Q.31
  localparam int ACC_W = 35;
  localparam int CELLS = 5;
  localparam int QM_W  = 13;
  localparam int Y_W   = 48;

  typedef logic signed [ACC_W-1:0] acc_t;

  // Side data that travels with each angle down the Horner chain
  typedef struct packed {
    logic [30:0] t;       // y*y/4, Q.31
    logic [31:0] y_mag;   // |y|, Q.31
    logic        y_neg;
    logic        flip;    // cosine is negated
  } side_t;

  localparam logic [31:0] INV_TWO_PI_Q32 = 32'h28BE60DC;
  localparam logic [63:0] PI_Q60         = 64'h3243F6A8885A308D;
  localparam logic [Y_W-1:0] PI_Q44      = Y_W'((PI_Q60 + 64'd32768) >> 16);
  localparam logic [Y_W-1:0] HALF_PI_Q44 = Y_W'((PI_Q60 + 64'd65536) >> 17);
  localparam logic [Y_W-1:0] TWO_PI_Q44  = Y_W'((PI_Q60 + 64'd16384) >> 15);

  // Coefficients times 4^k in Q.31; the last step of each lane adds 1.0
  localparam acc_t SIN_SEED = -35'sd52534;
  localparam acc_t SIN_STEP [CELLS] = '{
    35'sd1513234, -35'sd27269090, 35'sd286331073, -35'sd1431655794, 35'sd2147483648
  };
  localparam acc_t COS_SEED = -35'sd572881;
  localparam acc_t COS_STEP [CELLS] = '{
    35'sd13612226, -35'sd190880414, 35'sd1431654780, -35'sd4294967296, 35'sd2147483648
  };

endpackage

>>> hw/rtl/msc_reduce.sv
// Range reduction: turn count, remainder, fold into +-pi/2 and t = y*y/4 (four stages).
`timescale 1ns / 1ps

module msc_reduce #(
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  angle_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output msc_pkg::side_t      out_side_o
);

  localparam int YW = msc_pkg::Y_W;
  localparam logic [63:0] QM_MAX = ((64'd1 << 31) * 64'(msc_pkg::INV_TWO_PI_Q32)
                                    + (64'd1 << (ANGLE_FRAC_BITS + 31)))
                                   >> (ANGLE_FRAC_BITS + 32);
  localparam logic [63:0] Y_MAX  = (64'(msc_pkg::HALF_PI_Q44) + 64'd4096) >> 13;
  localparam logic [63:0] T_MAX  = (Y_MAX * Y_MAX + (64'd1 << 32)) >> 33;
  localparam logic signed [YW-1:0] HP_S = msc_pkg::HALF_PI_Q44;
  localparam logic signed [YW-1:0] PI_S = msc_pkg::PI_Q44;

  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1: turn count
  logic [31:0]               a_mag;
  logic [63:0]               q_prod;
  logic [63:0]               q_rnd;
  logic signed [31:0]        a1_q;
  logic [msc_pkg::QM_W-1:0]  qm1_q;
  logic                      neg1_q;

  assign a_mag  = angle_i[31] ? (32'd0 - angle_i) : angle_i;
  assign q_prod = 64'(a_mag) * 64'(msc_pkg::INV_TWO_PI_Q32);
  assign q_rnd  = (q_prod + (64'd1 << (ANGLE_FRAC_BITS + 31))) >> (ANGLE_FRAC_BITS + 32);

  // stage 2: remainder y = a - 2 pi q in Q.44
  logic signed [63:0]  a_ext;
  logic [60:0]         q_off;
  logic signed [63:0]  y_full;
  logic signed [YW-1:0] y2_q;

  assign a_ext  = 64'(a1_q) <<< (44 - ANGLE_FRAC_BITS);
  assign q_off  = 61'(qm1_q) * 61'(msc_pkg::TWO_PI_Q44);
  assign y_full = neg1_q ? (a_ext + $signed(64'(q_off))) : (a_ext - $signed(64'(q_off)));

  // stage 3: fold and round to Q.31
  logic signed [YW-1:0] y_fold;
  logic                 fold;
  logic [YW-1:0]        yf_mag;
  logic [YW-1:0]        yf_rnd;
  logic [31:0]          ymag3_q;
  logic                 yneg3_q;
  logic                 flip3_q;

  always_comb begin
    y_fold = y2_q;
    fold   = 1'b0;
    if (y2_q > HP_S) begin
      y_fold = PI_S - y2_q;
      fold   = 1'b1;
    end else if (y2_q < -HP_S) begin
      y_fold = -PI_S - y2_q;
      fold   = 1'b1;
    end
  end

  assign yf_mag = y_fold[YW-1] ? YW'(-y_fold) : YW'(y_fold);
  assign yf_rnd = (yf_mag + YW'(4096)) >> 13;

  // stage 4: t = y*y/4
  logic [63:0]     t_full;
  msc_pkg::side_t  side4_q;

  assign t_full = (64'(ymag3_q) * 64'(ymag3_q) + (64'd1 << 32)) >> 33;

  assign en4        = !v4_q || out_ready_i;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      a1_q   <= angle_i;
      qm1_q  <= q_rnd[msc_pkg::QM_W-1:0];
      neg1_q <= angle_i[31];
    end
    if (en2) begin
      y2_q <= y_full[YW-1:0];
    end
    if (en3) begin
      ymag3_q <= yf_rnd[31:0];
      yneg3_q <= y_fold[YW-1];
      flip3_q <= fold;
    end
    if (en4) begin
      side4_q.t     <= t_full[30:0];
      side4_q.y_mag <= ymag3_q;
      side4_q.y_neg <= yneg3_q;
      side4_q.flip  <= flip3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign out_side_o  = side4_q;

  a_qm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> 64'(qm1_q) <= QM_MAX)
    else $error("turn count out of range");

  a_y_folded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> 64'(ymag3_q) <= Y_MAX)
    else $error("folded angle exceeds pi/2");

  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> 64'(side4_q.t) <= T_MAX)
    else $error("t exceeds (pi/2)^2/4");

endmodule

>>> hw/rtl/msc_cell.sv
// One Horner cell: acc <- acc*t + coefficient for the sine and cosine lanes.
`timescale 1ns / 1ps

module msc_cell #(
  parameter int IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  msc_pkg::side_t  in_side_i,
  input  msc_pkg::acc_t   sin_acc_i,
  input  msc_pkg::acc_t   cos_acc_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output msc_pkg::side_t  out_side_o,
  output msc_pkg::acc_t   sin_acc_o,
  output msc_pkg::acc_t   cos_acc_o
);

  localparam int AW = msc_pkg::ACC_W;

  // acc * t / 2^31, rounded half away from zero
  function automatic msc_pkg::acc_t mul_t(msc_pkg::acc_t acc, logic [30:0] t);
    logic [AW-2:0]  mag;
    logic [AW+29:0] prod;
    logic [AW-2:0]  rnd;
    mag  = acc[AW-1] ? (AW-1)'(-acc) : (AW-1)'(acc);
    prod = (AW+30)'(mag) * (AW+30)'(t);
    rnd  = (AW-1)'((prod + ((AW+30)'(1) << 30)) >> 31);
    return acc[AW-1] ? -$signed(AW'(rnd)) : $signed(AW'(rnd));
  endfunction

  logic            en;
  logic            v_q;
  msc_pkg::side_t  side_q;
  msc_pkg::acc_t   sin_q, cos_q;

  assign en         = !v_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q <= in_side_i;
      sin_q  <= mul_t(sin_acc_i, in_side_i.t) + msc_pkg::SIN_STEP[IDX];
      cos_q  <= mul_t(cos_acc_i, in_side_i.t) + msc_pkg::COS_STEP[IDX];
    end
  end

  assign out_valid_o = v_q;
  assign out_side_o  = side_q;
  assign sin_acc_o   = sin_q;
  assign cos_acc_o   = cos_q;

endmodule

>>> hw/rtl/msc_out.sv
// Output cell: sine = y*S(t), cosine sign, rounding to the output format and saturation.
`timescale 1ns / 1ps

module msc_out #(
  parameter int OUT_FRAC_BITS = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  msc_pkg::side_t     in_side_i,
  input  msc_pkg::acc_t      sin_acc_i,
  input  msc_pkg::acc_t      cos_acc_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] sine_o,
  output logic signed [31:0] cosine_o
);

  localparam int AW = msc_pkg::ACC_W;
  localparam int SH = 31 - OUT_FRAC_BITS;
  localparam logic [AW-1:0] RND = AW'((64'd1 << SH) >> 1);
  localparam logic [AW-1:0] LIM = AW'(64'd1 << OUT_FRAC_BITS);
  localparam logic signed [31:0] LIM_S = 32'(64'd1 << OUT_FRAC_BITS);

  function automatic logic [31:0] to_out(msc_pkg::acc_t v);
    logic [AW-1:0] m;
    logic [AW-1:0] r;
    m = v[AW-1] ? AW'(-v) : AW'(v);
    r = (m + RND) >> SH;
    if (r > LIM) r = LIM;
    return v[AW-1] ? 32'(-r) : 32'(r);
  endfunction

  logic ena, enb;
  logic va_q, vb_q;

  // stage A: final product with y
  logic [AW-2:0]  hs_mag;
  logic [AW+31:0] s_prod;
  logic [AW-2:0]  s_rnd;
  logic           s_neg;
  msc_pkg::acc_t  s_val, c_val;
  msc_pkg::acc_t  sa_q, ca_q;

  assign hs_mag = sin_acc_i[AW-1] ? (AW-1)'(-sin_acc_i) : (AW-1)'(sin_acc_i);
  assign s_prod = (AW+32)'(hs_mag) * (AW+32)'(in_side_i.y_mag);
  assign s_rnd  = (AW-1)'((s_prod + ((AW+32)'(1) << 30)) >> 31);
  assign s_neg  = sin_acc_i[AW-1] ^ in_side_i.y_neg;
  assign s_val  = s_neg ? -$signed(AW'(s_rnd)) : $signed(AW'(s_rnd));
  assign c_val  = in_side_i.flip ? -cos_acc_i : cos_acc_i;

  logic signed [31:0] sine_q, cosine_q;

  assign enb        = !vb_q || out_ready_i;
  assign ena        = !va_q || enb;
  assign in_ready_o = ena;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ena) va_q <= in_valid_i;
      if (enb) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ena) begin
      sa_q <= s_val;
      ca_q <= c_val;
    end
    if (enb) begin
      sine_q   <= to_out(sa_q);
      cosine_q <= to_out(ca_q);
    end
  end

  assign out_valid_o = vb_q;
  assign sine_o      = sine_q;
  assign cosine_o    = cosine_q;

  a_sine_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q |-> (sine_q <= LIM_S) && (sine_q >= -LIM_S))
    else $error("sine outside +-1.0");

  a_cosine_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q |-> (cosine_q <= LIM_S) && (cosine_q >= -LIM_S))
    else $error("cosine outside +-1.0");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q && !out_ready_i |=> vb_q && $stable(sine_q) && $stable(cosine_q))
    else $error("stalled result changed");

endmodule

>>> hw/rtl/minimax_sine_cosine.sv
// Top level of the minimax sine/cosine pipeline.
//
// Usage: one angle per transaction enters on s_axis (tdata = radians, signed,
// ANGLE_FRAC_BITS fraction bits). Each angle yields one transaction on m_axis
// with tdata = {cosine, sine}, both signed with OUT_FRAC_BITS fraction bits and
// saturated to +-1.0.
// Stages: four range-reduction stages, five Horner cells, two output stages.
// Throughput: one angle per cycle while m_axis_tready is high; every stage
// holds one item and hands it to its neighbor when the neighbor can take it.
// Stalls: each stage has its own valid bit and takes a new item whenever it is
// empty or its neighbor moves, so bubbles close up and s_axis_tready stays
// high while the output waits until the whole chain (11 items) is full.
// Reset: clears all valid bits; the data registers are not reset, and
// s_axis_tready is high as soon as the valid bits are clear.
`timescale 1ns / 1ps

module minimax_sine_cosine #(
  parameter int ANGLE_FRAC_BITS = 24,
  parameter int OUT_FRAC_BITS   = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] angle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [31:0] sine, [63:32] cosine
);

  localparam int N = msc_pkg::CELLS;

  logic            valid [N+1];
  logic            ready [N+1];
  msc_pkg::side_t  side  [N+1];
  msc_pkg::acc_t   sacc  [N+1];
  msc_pkg::acc_t   cacc  [N+1];

  logic signed [31:0] sine, cosine;

  msc_reduce #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .angle_i    ($signed(s_axis_tdata)),
    .out_valid_o(valid[0]),
    .out_ready_i(ready[0]),
    .out_side_o (side[0])
  );

  assign sacc[0] = msc_pkg::SIN_SEED;
  assign cacc[0] = msc_pkg::COS_SEED;

  for (genvar g = 0; g < N; g++) begin : g_cell
    msc_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (valid[g]),
      .in_ready_o (ready[g]),
      .in_side_i  (side[g]),
      .sin_acc_i  (sacc[g]),
      .cos_acc_i  (cacc[g]),
      .out_valid_o(valid[g+1]),
      .out_ready_i(ready[g+1]),
      .out_side_o (side[g+1]),
      .sin_acc_o  (sacc[g+1]),
      .cos_acc_o  (cacc[g+1])
    );
  end

  msc_out #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (valid[N]),
    .in_ready_o (ready[N]),
    .in_side_i  (side[N]),
    .sin_acc_i  (sacc[N]),
    .cos_acc_i  (cacc[N]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sine_o     (sine),
    .cosine_o   (cosine)
  );

  assign m_axis_tdata = {cosine, sine};

endmodule
